### rtl/core/rwhp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rwhp_pkg;

    // four-byte tags, first byte in the top bits
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    // fmt chunk body length that is always read
    localparam logic [31:0] FMT_BODY_BYTES = 32'd16;
    localparam logic [4:0]  FMT_LAST_POS   = 5'd15;
    localparam logic [4:0]  FMT_BITS_POS   = 5'd14;
    localparam logic [4:0]  HDR_LAST_POS   = 5'd7;
    localparam logic [4:0]  RIFF_TAG_POS   = 5'd3;
    localparam logic [4:0]  WAVE_TAG_POS   = 5'd11;

    localparam logic [9:0]  MS_PER_S = 10'd1000;

    // widths of the duration path
    localparam int DUR_W = 42;
    localparam int DVS_W = 32;
    localparam int BPS_W = 22;

    // phase codes reported on each result word
    localparam logic [2:0] PH_RIFF    = 3'd0;
    localparam logic [2:0] PH_CHUNK   = 3'd1;
    localparam logic [2:0] PH_FMT     = 3'd2;
    localparam logic [2:0] PH_INFO    = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_END     = 3'd5;

    // sample encoding kinds
    localparam logic [2:0] KIND_LINEAR  = 3'd0;
    localparam logic [2:0] KIND_FLOAT   = 3'd1;
    localparam logic [2:0] KIND_ALAW    = 3'd2;
    localparam logic [2:0] KIND_MULAW   = 3'd3;
    localparam logic [2:0] KIND_UNKNOWN = 3'd4;

    typedef enum logic [2:0] {
        PS_RIFF,
        PS_CHUNK,
        PS_FMT,
        PS_SKIP,
        PS_PAYLOAD,
        PS_END
    } rwhp_parse_state_t;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_DIV1,
        BS_SCALE,
        BS_DIV2,
        BS_EMIT
    } rwhp_back_state_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       restart;
    } rwhp_in_t;

    typedef struct packed {
        logic [2:0]       phase;
        logic [7:0]       payload_byte;
        logic             payload_last;
        logic             info_valid;
        logic [15:0]      format_tag;
        logic [15:0]      channel_count;
        logic [31:0]      sample_rate;
        logic [7:0]       sample_bits;
        logic [2:0]       pcm_kind;
        logic             samples_signed;
        logic [31:0]      data_bytes;
        logic [DUR_W-1:0] duration_ms;
    } rwhp_result_t;

    // word handed from the parser to the back end
    typedef struct packed {
        rwhp_result_t     res;
        logic             is_info;
        logic             zero_div;
        logic [BPS_W-1:0] bps;
    } rwhp_cmd_t;

    typedef struct packed {
        logic             start;
        logic [DUR_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } rwhp_div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DUR_W-1:0] quotient;
    } rwhp_div_rsp_t;

    function automatic logic [2:0] kind_of(input logic [15:0] tag);
        logic [2:0] k;
        unique case (tag)
            16'd0, 16'd1: k = KIND_LINEAR;
            16'd3:        k = KIND_FLOAT;
            16'd6:        k = KIND_ALAW;
            16'd7:        k = KIND_MULAW;
            default:      k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

### rtl/core/rwhp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rwhp_front
    import rwhp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      accept,
    input  wire rwhp_in_t  in_item,
    output rwhp_cmd_t      cmd
);

    rwhp_parse_state_t state_reg, state_next;
    logic [4:0]  pos_reg, pos_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] skip_reg, skip_next;
    logic        seen_reg, seen_next;
    logic [15:0] ftag_reg, ftag_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [7:0]  bits_reg, bits_next;
    logic [31:0] drem_reg, drem_next;

    // parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PS_RIFF;
            pos_reg   <= '0;
            tag_reg   <= '0;
            size_reg  <= '0;
            skip_reg  <= '0;
            seen_reg  <= 1'b0;
            ftag_reg  <= '0;
            chan_reg  <= '0;
            rate_reg  <= '0;
            bits_reg  <= '0;
            drem_reg  <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            tag_reg   <= tag_next;
            size_reg  <= size_next;
            skip_reg  <= skip_next;
            seen_reg  <= seen_next;
            ftag_reg  <= ftag_next;
            chan_reg  <= chan_next;
            rate_reg  <= rate_next;
            bits_reg  <= bits_next;
            drem_reg  <= drem_next;
        end
    end

    // per-byte parse step, restart clears everything first
    always_comb
    begin
        logic [7:0]  b;
        logic [31:0] b32;
        logic [5:0]  bytes_per_ch;
        b   = in_item.in_byte;
        b32 = {24'b0, b};

        if (in_item.restart)
        begin
            state_next = PS_RIFF;
            pos_next   = '0;
            tag_next   = '0;
            size_next  = '0;
            skip_next  = '0;
            seen_next  = 1'b0;
            ftag_next  = '0;
            chan_next  = '0;
            rate_next  = '0;
            bits_next  = '0;
            drem_next  = '0;
        end
        else
        begin
            state_next = state_reg;
            pos_next   = pos_reg;
            tag_next   = tag_reg;
            size_next  = size_reg;
            skip_next  = skip_reg;
            seen_next  = seen_reg;
            ftag_next  = ftag_reg;
            chan_next  = chan_reg;
            rate_next  = rate_reg;
            bits_next  = bits_reg;
            drem_next  = drem_reg;
        end

        cmd = '0;
        bytes_per_ch = 6'(({1'b0, bits_next} + 9'd7) >> 3);
        cmd.bps = BPS_W'(bytes_per_ch) * BPS_W'(chan_next);

        unique case (state_next)
            PS_RIFF:
            begin
                cmd.res.phase = PH_RIFF;
                tag_next = {tag_next[23:0], b};
                if ((pos_next == RIFF_TAG_POS && tag_next != TAG_RIFF) ||
                    (pos_next == WAVE_TAG_POS && tag_next != TAG_WAVE))
                begin
                    state_next = PS_END;
                    cmd.res.phase = PH_END;
                end
                else if (pos_next == WAVE_TAG_POS)
                begin
                    state_next = PS_CHUNK;
                    pos_next = '0;
                end
                else
                begin
                    pos_next = pos_next + 5'd1;
                end
            end
            PS_CHUNK:
            begin
                cmd.res.phase = PH_CHUNK;
                if (pos_next < 5'd4)
                begin
                    tag_next = {tag_next[23:0], b};
                    if (pos_next == 5'd0)
                        size_next = '0;
                end
                else
                begin
                    size_next = size_next | (b32 << {pos_next[1:0], 3'b000});
                end
                if (pos_next < HDR_LAST_POS)
                begin
                    pos_next = pos_next + 5'd1;
                end
                else
                begin
                    pos_next = '0;
                    if (!seen_next && tag_next == TAG_FMT)
                    begin
                        seen_next = 1'b1;
                        state_next = PS_FMT;
                    end
                    else if (seen_next && tag_next == TAG_DATA)
                    begin
                        drem_next = size_next;
                        state_next = (size_next == '0) ? PS_END : PS_PAYLOAD;
                        cmd.is_info = 1'b1;
                        cmd.zero_div = (cmd.bps == '0) || (rate_next == '0);
                        cmd.res.phase = PH_INFO;
                        cmd.res.info_valid = 1'b1;
                        cmd.res.format_tag = ftag_next;
                        cmd.res.channel_count = chan_next;
                        cmd.res.sample_rate = rate_next;
                        cmd.res.sample_bits = bits_next;
                        cmd.res.pcm_kind = kind_of(ftag_next);
                        cmd.res.samples_signed = (bits_next > 8'd8);
                        cmd.res.data_bytes = size_next;
                    end
                    else
                    begin
                        skip_next = size_next;
                        state_next = (size_next == '0) ? PS_CHUNK : PS_SKIP;
                    end
                end
            end
            PS_FMT:
            begin
                cmd.res.phase = PH_FMT;
                priority if (pos_next == 5'd0)
                begin
                    ftag_next = {8'b0, b};
                    chan_next = '0;
                    rate_next = '0;
                    bits_next = '0;
                end
                else if (pos_next == 5'd1)
                    ftag_next = ftag_next | {b, 8'b0};
                else if (pos_next == 5'd2)
                    chan_next = {8'b0, b};
                else if (pos_next == 5'd3)
                    chan_next = chan_next | {b, 8'b0};
                else if (pos_next >= 5'd4 && pos_next <= 5'd7)
                    rate_next = rate_next | (b32 << {pos_next[1:0], 3'b000});
                else if (pos_next == FMT_BITS_POS)
                    bits_next = b;
                else
                    bits_next = bits_next;

                if (pos_next < FMT_LAST_POS)
                begin
                    pos_next = pos_next + 5'd1;
                end
                else
                begin
                    pos_next = '0;
                    skip_next = (size_next > FMT_BODY_BYTES) ?
                                size_next - FMT_BODY_BYTES : '0;
                    state_next = (skip_next != '0) ? PS_SKIP : PS_CHUNK;
                end
            end
            PS_SKIP:
            begin
                cmd.res.phase = PH_CHUNK;
                skip_next = (skip_next != '0) ? skip_next - 32'd1 : '0;
                if (skip_next == '0)
                begin
                    state_next = PS_CHUNK;
                    pos_next = '0;
                end
            end
            PS_PAYLOAD:
            begin
                cmd.res.phase = PH_PAYLOAD;
                cmd.res.payload_byte = b;
                drem_next = (drem_next != '0) ? drem_next - 32'd1 : '0;
                if (drem_next == '0)
                begin
                    cmd.res.payload_last = 1'b1;
                    state_next = PS_END;
                end
            end
            default:
            begin
                cmd.res.phase = PH_END;
                state_next = PS_END;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/rwhp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module rwhp_queue
    import rwhp_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      wr_en,
    input  wire rwhp_cmd_t wr_data,
    input  wire logic      rd_en,
    output rwhp_cmd_t      rd_data,
    output logic           full,
    output logic           empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rwhp_cmd_t        slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_wr && !do_rd)
            count_next = count_reg + CNT_W'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage slots
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count above depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == CNT_W'(DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

### rtl/core/rwhp_div.sv
`timescale 1ns / 1ps
`default_nettype none

module rwhp_div
    import rwhp_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire rwhp_div_req_t req,
    output rwhp_div_rsp_t      rsp
);

    localparam int CNT_W = $clog2(DUR_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVS_W:0]   rem_reg;
    logic [DUR_W-1:0] quo_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W:0]   rem_shift;
    logic             fits;

    // one restoring step per cycle, quotient bits shift in as dividend bits shift out
    assign rem_shift = {rem_reg[DVS_W-1:0], quo_reg[DUR_W-1]};
    assign fits      = (rem_shift >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(DUR_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_shift - {1'b0, dvs_reg} : rem_shift;
            quo_reg <= {quo_reg[DUR_W-2:0], fits};
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

endmodule

`default_nettype wire

### rtl/core/rwhp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module rwhp_back
    import rwhp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire rwhp_cmd_t q_data,
    input  wire logic      q_empty,
    output logic           q_pop,
    output rwhp_result_t   result,
    output logic           empty,
    input  wire logic      pop
);

    rwhp_back_state_t state_reg, state_next;
    rwhp_result_t     info_reg, info_next;
    logic [31:0]      q1_reg, q1_next;
    rwhp_result_t     out_reg, out_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;
    rwhp_div_req_t    div_req;
    rwhp_div_rsp_t    div_rsp;

    rwhp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign out_free = !out_valid_reg || pop;
    assign result   = out_reg;
    assign empty    = !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BS_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        info_reg <= info_next;
        q1_reg   <= q1_next;
        out_reg  <= out_next;
    end

    // sequencer: plain words go straight out, info words get a computed or zero duration
    always_comb
    begin
        state_next     = state_reg;
        info_next      = info_reg;
        q1_next        = q1_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        q_pop          = 1'b0;
        div_req        = '0;

        unique case (state_reg)
            BS_IDLE:
            begin
                if (!q_empty)
                begin
                    if (!q_data.is_info)
                    begin
                        if (out_free)
                        begin
                            q_pop          = 1'b1;
                            out_next       = q_data.res;
                            out_valid_next = 1'b1;
                        end
                    end
                    else
                    begin
                        q_pop     = 1'b1;
                        info_next = q_data.res;
                        if (q_data.zero_div)
                        begin
                            info_next.duration_ms = '0;
                            state_next = BS_EMIT;
                        end
                        else
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = DUR_W'(q_data.res.data_bytes);
                            div_req.divisor  = DVS_W'(q_data.bps);
                            state_next = BS_DIV1;
                        end
                    end
                end
            end
            BS_DIV1:
            begin
                if (div_rsp.done)
                begin
                    q1_next    = div_rsp.quotient[31:0];
                    state_next = BS_SCALE;
                end
            end
            BS_SCALE:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DUR_W'(q1_reg) * DUR_W'(MS_PER_S);
                div_req.divisor  = info_reg.sample_rate;
                state_next = BS_DIV2;
            end
            BS_DIV2:
            begin
                if (div_rsp.done)
                begin
                    info_next.duration_ms = div_rsp.quotient;
                    state_next = BS_EMIT;
                end
            end
            BS_EMIT:
            begin
                if (out_free)
                begin
                    out_next       = info_reg;
                    out_valid_next = 1'b1;
                    state_next     = BS_IDLE;
                end
            end
            default:
            begin
                state_next = BS_IDLE;
            end
        endcase
    end

    a_div_running: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BS_DIV1 || state_reg == BS_DIV2) |-> (div_rsp.busy || div_rsp.done))
        else $error("waiting on divider that is not running");

    a_no_pop_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != BS_IDLE) |-> !q_pop)
        else $error("queue popped during duration math");

endmodule

`default_nettype wire

### rtl/core/riff_wave_header_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake          word
// in_item   in         push / full        in_byte, restart
// result    out        empty / pop        phase, payload and format info, duration
//
// Plain bytes pass from the front end through the queue into the output register.
// The word that completes the data chunk header runs through the back end as two
// serial divisions of 42 steps each around a scale state, or none on a zero divisor;
// bytes keep being accepted meanwhile until the QUEUE_DEPTH-entry queue fills.
// Reset is asynchronous and takes effect at once, with no clearing pass.
// full rises when the queue is full; a stalled pop holds the result word.

module riff_wave_header_parser
    import rwhp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire rwhp_in_t in_item,
    input  wire logic     push,
    output logic          full,
    output rwhp_result_t  result,
    output logic          empty,
    input  wire logic     pop
);

    logic      accept;
    rwhp_cmd_t front_cmd;
    rwhp_cmd_t q_data;
    logic      q_empty;
    logic      q_pop;

    assign accept = push && !full;

    rwhp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_item (in_item),
        .cmd     (front_cmd)
    );

    rwhp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (front_cmd),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .full    (full),
        .empty   (q_empty)
    );

    rwhp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_data),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

endmodule

`default_nettype wire
